@@ rtl/hsvc_pkg.sv @@
// ----------------------------------------------------------------------------
// hsvc_pkg
// Shared widths, register map, codes and controller/datapath interface types
// for the two-color hsv centroid compare unit.
// ----------------------------------------------------------------------------
package hsvc_pkg;

  // frame geometry
  localparam int FRAME_WIDTH = 320;

  // field widths
  localparam int PIX_W    = 8;
  localparam int COL_W    = 9;
  localparam int VERD_W   = 2;
  localparam int SUM_W    = 25;
  localparam int CNT_W    = 17;
  localparam int STEP_W   = $clog2(SUM_W);
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  // saturation limits of the accumulators
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // clamp value for out-of-range columns
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(FRAME_WIDTH - 1);

  // verdict codes
  localparam logic [VERD_W-1:0] VERDICT_NONE   = 2'd0;
  localparam logic [VERD_W-1:0] VERDICT_ABSENT = 2'd1;
  localparam logic [VERD_W-1:0] VERDICT_RIGHT  = 2'd2;
  localparam logic [VERD_W-1:0] VERDICT_LEFT   = 2'd3;

  // register indexes
  localparam logic [2:0] REG_BLUE_HUE_LOW  = 3'd0;
  localparam logic [2:0] REG_BLUE_HUE_HIGH = 3'd1;
  localparam logic [2:0] REG_RED_HUE_LOW   = 3'd2;
  localparam logic [2:0] REG_RED_HUE_HIGH  = 3'd3;
  localparam logic [2:0] REG_MIN_SAT       = 3'd4;
  localparam logic [2:0] REG_MIN_BRIGHT    = 3'd5;

  // register reset values
  localparam logic [PIX_W-1:0] RST_BLUE_HUE_LOW  = 8'd95;
  localparam logic [PIX_W-1:0] RST_BLUE_HUE_HIGH = 8'd135;
  localparam logic [PIX_W-1:0] RST_RED_HUE_LOW   = 8'd165;
  localparam logic [PIX_W-1:0] RST_RED_HUE_HIGH  = 8'd180;
  localparam logic [PIX_W-1:0] RST_MIN_SAT       = 8'd50;
  localparam logic [PIX_W-1:0] RST_MIN_BRIGHT    = 8'd50;

  // thresholds as seen by the datapath
  typedef struct packed {
    logic [PIX_W-1:0] blue_hue_low;
    logic [PIX_W-1:0] blue_hue_high;
    logic [PIX_W-1:0] red_hue_low;
    logic [PIX_W-1:0] red_hue_high;
    logic [PIX_W-1:0] min_saturation;
    logic [PIX_W-1:0] min_brightness;
  } cfg_t;

  // controller to datapath commands
  typedef struct packed {
    logic accept;      // take the pixel transaction
    logic div_load_b;  // load the divider with the blue snapshot
    logic div_load_r;  // save blue mean, load the divider with the red snapshot
    logic div_step;    // one restoring division step
    logic load_pix;    // load output with a plain pixel result
    logic load_frame;  // load output with the frame-end result
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic frame_end;   // current input carries the frame-end mark
    logic absent;      // snapshot has a color with no hits
  } sts_t;

endpackage

@@ rtl/hsvc_regs.sv @@
// ----------------------------------------------------------------------------
// hsvc_regs
// Threshold register bank behind the apb-style configuration port.
// ----------------------------------------------------------------------------
module hsvc_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [hsvc_pkg::ADDR_W-1:0]  paddr,
  input  logic [hsvc_pkg::DATA_W-1:0]  pwdata,
  output logic [hsvc_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output hsvc_pkg::cfg_t               cfg
);
  import hsvc_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;
  assign cfg     = cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.blue_hue_low   <= RST_BLUE_HUE_LOW;
      cfg_r.blue_hue_high  <= RST_BLUE_HUE_HIGH;
      cfg_r.red_hue_low    <= RST_RED_HUE_LOW;
      cfg_r.red_hue_high   <= RST_RED_HUE_HIGH;
      cfg_r.min_saturation <= RST_MIN_SAT;
      cfg_r.min_brightness <= RST_MIN_BRIGHT;
    end else if (wr_en) begin
      case (reg_idx)
        REG_BLUE_HUE_LOW:  cfg_r.blue_hue_low   <= pwdata[PIX_W-1:0];
        REG_BLUE_HUE_HIGH: cfg_r.blue_hue_high  <= pwdata[PIX_W-1:0];
        REG_RED_HUE_LOW:   cfg_r.red_hue_low    <= pwdata[PIX_W-1:0];
        REG_RED_HUE_HIGH:  cfg_r.red_hue_high   <= pwdata[PIX_W-1:0];
        REG_MIN_SAT:       cfg_r.min_saturation <= pwdata[PIX_W-1:0];
        REG_MIN_BRIGHT:    cfg_r.min_brightness <= pwdata[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_BLUE_HUE_LOW:  prdata = DATA_W'(cfg_r.blue_hue_low);
      REG_BLUE_HUE_HIGH: prdata = DATA_W'(cfg_r.blue_hue_high);
      REG_RED_HUE_LOW:   prdata = DATA_W'(cfg_r.red_hue_low);
      REG_RED_HUE_HIGH:  prdata = DATA_W'(cfg_r.red_hue_high);
      REG_MIN_SAT:       prdata = DATA_W'(cfg_r.min_saturation);
      REG_MIN_BRIGHT:    prdata = DATA_W'(cfg_r.min_brightness);
      default:           prdata = '0;
    endcase
  end

endmodule

@@ rtl/hsvc_dp.sv @@
// ----------------------------------------------------------------------------
// hsvc_dp
// Pixel classification, column accumulators, frame snapshot, shared
// bit-serial divider and output payload registers.
// ----------------------------------------------------------------------------
module hsvc_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  hsvc_pkg::cfg_t                cfg,
  input  hsvc_pkg::cmd_t                cmd,
  output hsvc_pkg::sts_t                sts,
  input  logic [hsvc_pkg::PIX_W-1:0]    in_hue,
  input  logic [hsvc_pkg::PIX_W-1:0]    in_saturation,
  input  logic [hsvc_pkg::PIX_W-1:0]    in_brightness,
  input  logic [hsvc_pkg::COL_W-1:0]    in_column,
  input  logic                          in_frame_end,
  output logic                          out_blue_hit,
  output logic                          out_red_hit,
  output logic [hsvc_pkg::VERD_W-1:0]   out_verdict
);
  import hsvc_pkg::*;

  // accumulators
  logic [SUM_W-1:0] b_sum_r, r_sum_r;
  logic [CNT_W-1:0] b_cnt_r, r_cnt_r;
  // frame-end snapshot
  logic [SUM_W-1:0] snap_b_sum_r, snap_r_sum_r;
  logic [CNT_W-1:0] snap_b_cnt_r, snap_r_cnt_r;
  logic             absent_r;
  logic             pend_blue_r, pend_red_r;
  // divider
  logic [SUM_W-1:0] dvd_r;
  logic [CNT_W-1:0] dsr_r;
  logic [CNT_W-1:0] rem_r;
  logic [SUM_W-1:0] bmean_r;
  // output payload
  logic             out_blue_r, out_red_r;
  logic [VERD_W-1:0] out_verdict_r;

  logic             passes_floor, blue, red;
  logic [COL_W-1:0] col;
  logic [SUM_W:0]   b_sum_add, r_sum_add;
  logic [SUM_W-1:0] b_sum_nxt, r_sum_nxt;
  logic [CNT_W-1:0] b_cnt_nxt, r_cnt_nxt;
  logic [CNT_W:0]   trial;
  logic [CNT_W:0]   diff;
  logic             ge;
  logic [VERD_W-1:0] frame_verdict;

  // color tests
  assign passes_floor = (in_saturation >= cfg.min_saturation) &&
                        (in_brightness >= cfg.min_brightness);
  assign blue   = passes_floor && (in_hue >= cfg.blue_hue_low) &&
                  (in_hue <= cfg.blue_hue_high);
  assign red    = passes_floor && (in_hue >= cfg.red_hue_low) &&
                  (in_hue <= cfg.red_hue_high);

  // column clamp
  assign col = (in_column > COL_LAST) ? COL_LAST : in_column;

  // saturating accumulator updates
  always_comb begin
    b_sum_add = {1'b0, b_sum_r} + (SUM_W+1)'(col);
    r_sum_add = {1'b0, r_sum_r} + (SUM_W+1)'(col);
    b_sum_nxt = b_sum_r;
    b_cnt_nxt = b_cnt_r;
    r_sum_nxt = r_sum_r;
    r_cnt_nxt = r_cnt_r;
    if (blue) begin
      b_sum_nxt = b_sum_add[SUM_W] ? SUM_MAX : b_sum_add[SUM_W-1:0];
      b_cnt_nxt = (b_cnt_r == CNT_MAX) ? b_cnt_r : b_cnt_r + CNT_W'(1);
    end
    if (red) begin
      r_sum_nxt = r_sum_add[SUM_W] ? SUM_MAX : r_sum_add[SUM_W-1:0];
      r_cnt_nxt = (r_cnt_r == CNT_MAX) ? r_cnt_r : r_cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_sum_r <= '0;
      b_cnt_r <= '0;
      r_sum_r <= '0;
      r_cnt_r <= '0;
    end else if (cmd.accept) begin
      if (in_frame_end) begin
        b_sum_r <= '0;
        b_cnt_r <= '0;
        r_sum_r <= '0;
        r_cnt_r <= '0;
      end else begin
        b_sum_r <= b_sum_nxt;
        b_cnt_r <= b_cnt_nxt;
        r_sum_r <= r_sum_nxt;
        r_cnt_r <= r_cnt_nxt;
      end
    end
  end

  // snapshot of the finished frame, including the frame-end pixel
  always_ff @(posedge clk) begin
    if (cmd.accept && in_frame_end) begin
      snap_b_sum_r <= b_sum_nxt;
      snap_b_cnt_r <= b_cnt_nxt;
      snap_r_sum_r <= r_sum_nxt;
      snap_r_cnt_r <= r_cnt_nxt;
      absent_r     <= (b_cnt_nxt == '0) || (r_cnt_nxt == '0);
      pend_blue_r  <= blue;
      pend_red_r   <= red;
    end
  end

  assign sts.frame_end = in_frame_end;
  assign sts.absent    = absent_r;

  // restoring divider step, one quotient bit per cycle
  assign trial = {rem_r, dvd_r[SUM_W-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign ge    = (trial >= {1'b0, dsr_r});

  always_ff @(posedge clk) begin
    if (cmd.div_load_b) begin
      dvd_r <= snap_b_sum_r;
      dsr_r <= snap_b_cnt_r;
      rem_r <= '0;
    end else if (cmd.div_load_r) begin
      bmean_r <= dvd_r;
      dvd_r   <= snap_r_sum_r;
      dsr_r   <= snap_r_cnt_r;
      rem_r   <= '0;
    end else if (cmd.div_step) begin
      rem_r <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      dvd_r <= {dvd_r[SUM_W-2:0], ge};
    end
  end

  // frame verdict: divider holds the red mean after the second pass
  assign frame_verdict = absent_r           ? VERDICT_ABSENT :
                         (bmean_r > dvd_r)  ? VERDICT_RIGHT  : VERDICT_LEFT;

  // output payload register
  always_ff @(posedge clk) begin
    if (cmd.load_pix) begin
      out_blue_r    <= blue;
      out_red_r     <= red;
      out_verdict_r <= VERDICT_NONE;
    end else if (cmd.load_frame) begin
      out_blue_r    <= pend_blue_r;
      out_red_r     <= pend_red_r;
      out_verdict_r <= frame_verdict;
    end
  end

  assign out_blue_hit = out_blue_r;
  assign out_red_hit  = out_red_r;
  assign out_verdict  = out_verdict_r;

endmodule

@@ rtl/hsvc_ctrl.sv @@
// ----------------------------------------------------------------------------
// hsvc_ctrl
// Sequencer: pixel acceptance, frame-end division passes and output valid.
// ----------------------------------------------------------------------------
module hsvc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  hsvc_pkg::sts_t  sts,
  output hsvc_pkg::cmd_t  cmd
);
  import hsvc_pkg::*;

  typedef enum logic [5:0] {
    S_RUN    = 6'b000001,
    S_CHECK  = 6'b000010,
    S_DIV_B  = 6'b000100,
    S_LOAD_R = 6'b001000,
    S_DIV_R  = 6'b010000,
    S_EMIT   = 6'b100000
  } state_t;

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SUM_W - 1);

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_free;
  logic              accept;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_RUN) && out_free;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      S_RUN: begin
        if (accept) begin
          cmd.accept = 1'b1;
          if (sts.frame_end) begin
            state_nxt = S_CHECK;
          end else begin
            cmd.load_pix  = 1'b1;
            out_valid_nxt = 1'b1;
          end
        end
      end
      S_CHECK: begin
        if (sts.absent) begin
          state_nxt = S_EMIT;
        end else begin
          cmd.div_load_b = 1'b1;
          step_nxt       = '0;
          state_nxt      = S_DIV_B;
        end
      end
      S_DIV_B: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + STEP_W'(1);
        if (step_r == STEP_LAST) begin
          state_nxt = S_LOAD_R;
        end
      end
      S_LOAD_R: begin
        cmd.div_load_r = 1'b1;
        step_nxt       = '0;
        state_nxt      = S_DIV_R;
      end
      S_DIV_R: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + STEP_W'(1);
        if (step_r == STEP_LAST) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.load_frame = 1'b1;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_RUN;
        end
      end
      default: begin
        state_nxt = S_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RUN;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ rtl/hsv_two_color_centroid_compare_unit.sv @@
// ----------------------------------------------------------------------------
// hsv_two_color_centroid_compare_unit
// Classifies hsv pixels as blue or red and compares per-frame mean columns.
// ----------------------------------------------------------------------------
// Every pixel transaction gives one result transaction. An ordinary pixel is
// taken while the output register is free, so a stream can run at one pixel
// per clock while the output register is drained. The frame-end pixel starts
// two 25-step restoring divisions on one shared bit-serial divider (blue mean,
// then red mean); the next pixel is taken after S_CHECK, S_DIV_B, S_LOAD_R,
// S_DIV_R and S_EMIT, or after S_CHECK and S_EMIT alone when a color had no
// hits. Thresholds sit behind the apb-style port at byte addresses 0 to 20
// and should only be written while no frame-end result is pending.
// ----------------------------------------------------------------------------
module hsv_two_color_centroid_compare_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  // pixel channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [hsvc_pkg::PIX_W-1:0]    in_hue,
  input  logic [hsvc_pkg::PIX_W-1:0]    in_saturation,
  input  logic [hsvc_pkg::PIX_W-1:0]    in_brightness,
  input  logic [hsvc_pkg::COL_W-1:0]    in_column,
  input  logic                          in_frame_end,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_blue_hit,
  output logic                          out_red_hit,
  output logic [hsvc_pkg::VERD_W-1:0]   out_verdict,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hsvc_pkg::ADDR_W-1:0]   paddr,
  input  logic [hsvc_pkg::DATA_W-1:0]   pwdata,
  output logic [hsvc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import hsvc_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  // threshold registers
  hsvc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer
  hsvc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath
  hsvc_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .cmd           (cmd),
    .sts           (sts),
    .in_hue        (in_hue),
    .in_saturation (in_saturation),
    .in_brightness (in_brightness),
    .in_column     (in_column),
    .in_frame_end  (in_frame_end),
    .out_blue_hit  (out_blue_hit),
    .out_red_hit   (out_red_hit),
    .out_verdict   (out_verdict)
  );

endmodule
